>>> hw/rtl/dcicc_pkg.sv
package dcicc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int LOOP_W      = 16;
  localparam int LIMIT_W     = 4;
  localparam int HOLD_W      = 24;
  localparam int COUNT_W     = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MISMATCH_LIM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAULT_HOLD   = 2'd2;

  localparam logic [LOOP_W-1:0]  LOOP_TIMEOUT_RST = 16'd1200;
  localparam logic [LIMIT_W-1:0] MISMATCH_LIM_RST = 4'd3;
  localparam logic [HOLD_W-1:0]  FAULT_HOLD_RST   = 24'd1000000;

  localparam logic [7:0] HDR_RUN = 8'hB8;
  localparam logic [7:0] PING_W0 = 8'hAC;
  localparam logic [7:0] PING_W1 = 8'hDC;
  localparam logic [7:0] PING_W2 = 8'hBE;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] rx_word0;
    logic [31:0] rx_word1;
    logic [31:0] rx_word2;
    logic        local_input;
    logic        transfer_ok;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_word0;
    logic [7:0] tx_word1;
    logic [7:0] tx_word2;
    logic       safe_output;
    logic [1:0] mode;
  } rsp_t;

endpackage

>>> hw/rtl/dcicc_stream_if.sv
interface dcicc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/dual_channel_input_cross_check.sv
// A result is registered and appears in the cycle after its beat is accepted.
// Throughput: one beat per cycle; the input stalls only while a result waits
// in the output register and the result channel is not ready.
// Each beat's state update and result are computed in the cycle it is accepted.
// Reset is synchronous and active high; it restores the register defaults,
// enters the awaiting-ping mode and empties the output register.
module dual_channel_input_cross_check (
  input  logic                              clk,
  input  logic                              rst,
  dcicc_stream_if.sink                      req,
  dcicc_stream_if.source                    rsp,
  input  logic                              cfg_we,
  input  logic [dcicc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcicc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcicc_pkg::*;

  typedef enum logic [1:0] {
    MODE_PING = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_HOLD = 2'd2
  } mode_t;

  logic [LOOP_W-1:0]  loop_timeout;
  logic [LIMIT_W-1:0] mismatch_limit;
  logic [HOLD_W-1:0]  fault_hold;

  mode_t              mode, mode_next;
  logic               last_input, last_input_next;
  logic               fault_flag, fault_flag_next;
  logic [COUNT_W-1:0] mismatch_count, mismatch_count_next;
  logic [LOOP_W-1:0]  loop_ticks, loop_ticks_next;
  logic [HOLD_W-1:0]  hold_ticks, hold_ticks_next;
  logic               output_level, output_level_next;

  logic out_valid;
  rsp_t out_data, out_data_next;
  logic accept;
  logic fault;
  logic ping_match;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign ping_match = req.data.transfer_ok
                   && req.data.rx_word0 == {24'd0, PING_W0}
                   && req.data.rx_word1 == {24'd0, PING_W1}
                   && req.data.rx_word2 == {24'd0, PING_W2};

  always_comb begin
    mode_next           = mode;
    last_input_next     = last_input;
    fault_flag_next     = fault_flag;
    mismatch_count_next = mismatch_count;
    loop_ticks_next     = loop_ticks;
    hold_ticks_next     = hold_ticks;
    output_level_next   = output_level;
    fault               = 1'b0;

    if (req.data.operation == OP_TICK) begin
      unique case (mode)
        MODE_RUN: begin
          if (loop_ticks != {LOOP_W{1'b1}}) begin
            loop_ticks_next = loop_ticks + 1'b1;
          end
        end
        MODE_HOLD: begin
          if (hold_ticks != {HOLD_W{1'b1}}) begin
            hold_ticks_next = hold_ticks + 1'b1;
          end
          if (hold_ticks_next >= fault_hold) begin
            mode_next = MODE_PING;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode)
        MODE_PING: begin
          if (ping_match) begin
            mode_next           = MODE_RUN;
            last_input_next     = 1'b0;
            fault_flag_next     = 1'b0;
            mismatch_count_next = '0;
            loop_ticks_next     = '0;
            output_level_next   = 1'b1;
          end
        end
        MODE_RUN: begin
          fault = !req.data.transfer_ok || fault_flag
               || req.data.rx_word2 != {31'd0, fault_flag}
               || loop_ticks > loop_timeout;
          if (mismatch_count > {1'b0, mismatch_limit}) begin
            fault_flag_next = 1'b1;
          end else if (req.data.rx_word0 != {24'd0, HDR_RUN}
                    || req.data.rx_word1 != {31'd0, last_input}) begin
            if (mismatch_count != {COUNT_W{1'b1}}) begin
              mismatch_count_next = mismatch_count + 1'b1;
            end
          end else begin
            mismatch_count_next = '0;
          end
          last_input_next = req.data.local_input;
          loop_ticks_next = '0;
          if (fault) begin
            mode_next         = MODE_HOLD;
            output_level_next = 1'b0;
            hold_ticks_next   = '0;
          end else begin
            output_level_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (mode_next == MODE_RUN) begin
      out_data_next.tx_word0 = HDR_RUN;
      out_data_next.tx_word1 = {7'd0, last_input_next};
      out_data_next.tx_word2 = {7'd0, fault_flag_next};
    end else begin
      out_data_next.tx_word0 = PING_W0;
      out_data_next.tx_word1 = PING_W1;
      out_data_next.tx_word2 = PING_W2;
    end
    out_data_next.safe_output = output_level_next;
    out_data_next.mode        = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_timeout   <= LOOP_TIMEOUT_RST;
      mismatch_limit <= MISMATCH_LIM_RST;
      fault_hold     <= FAULT_HOLD_RST;
      mode           <= MODE_PING;
      last_input     <= 1'b0;
      fault_flag     <= 1'b0;
      mismatch_count <= '0;
      loop_ticks     <= '0;
      hold_ticks     <= '0;
      output_level   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOOP_TIMEOUT: loop_timeout   <= cfg_data[LOOP_W-1:0];
          REG_MISMATCH_LIM: mismatch_limit <= cfg_data[LIMIT_W-1:0];
          REG_FAULT_HOLD:   fault_hold     <= cfg_data[HOLD_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        mode           <= mode_next;
        last_input     <= last_input_next;
        fault_flag     <= fault_flag_next;
        mismatch_count <= mismatch_count_next;
        loop_ticks     <= loop_ticks_next;
        hold_ticks     <= hold_ticks_next;
        output_level   <= output_level_next;
        out_data       <= out_data_next;
        out_valid      <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
